[hw/rtl/vcsd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Voxel column span decoder package
// Shared types and constants: payload structs, decode phases and reset values.
// ----------------------------------------------------------------------------
package vcsd_pkg;

    localparam int unsigned DepthWidth = 9;
    localparam logic [DepthWidth-1:0] DepthMax = '1;
    localparam logic [7:0] ColumnDepthReset = 8'd255;

    typedef struct packed {
        logic [7:0]  span_byte;
        logic        column_start;
        logic [15:0] column_length;
    } in_item_t;

    typedef struct packed {
        logic [7:0] voxel_depth;
        logic [7:0] voxel_color;
        logic [7:0] normal_index;
        logic       run_error;
    } out_item_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } result_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SKIP,
        PH_COUNT,
        PH_COLOR,
        PH_NORMAL,
        PH_REPEAT
    } phase_t;

endpackage
`default_nettype wire

[hw/rtl/voxel_column_span_decoder_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Voxel column span decoder
// Run-length decoder for voxel column span bytes, one byte per transfer.
// ----------------------------------------------------------------------------
// The block takes one span byte in every cycle and keeps that rate as long as
// the result side is not stalled. A byte passes an input register, is decoded
// by the column state logic, and a voxel or overrun result then appears in the
// result register once that register is free or being emptied. Bytes that
// produce no result leave nothing on the output. The column depth register
// is written through the configuration channel, which is always ready, and
// should only be changed while no bytes are in flight.
module voxel_column_span_decoder_unit (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire vcsd_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output vcsd_pkg::out_item_t      m_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [7:0]          cfg_data
);

    logic               advance;
    logic               item_valid;
    vcsd_pkg::in_item_t item;
    vcsd_pkg::result_t  result;

    assign cfg_ready = 1'b1;

    vcsd_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    vcsd_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance),
        .result     (result)
    );

    vcsd_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .result     (result),
        .advance    (advance),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
`default_nettype wire

[hw/rtl/vcsd_in_reg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Voxel column span decoder input register
// Captures one span byte transfer and holds it until the decode stage advances.
// ----------------------------------------------------------------------------
module vcsd_in_reg (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire vcsd_pkg::in_item_t s_data,
    input  wire logic               advance,
    output logic                    item_valid,
    output vcsd_pkg::in_item_t      item
);

    logic               valid_reg;
    logic               valid_next;
    vcsd_pkg::in_item_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule
`default_nettype wire

[hw/rtl/vcsd_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Voxel column span decoder core
// Holds the column decode state and the depth register and decodes one byte.
// ----------------------------------------------------------------------------
module vcsd_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    input  wire logic [7:0]         cfg_data,
    input  wire logic               item_valid,
    input  wire vcsd_pkg::in_item_t item,
    input  wire logic               advance,
    output vcsd_pkg::result_t       result
);

    localparam int unsigned DW = vcsd_pkg::DepthWidth;

    vcsd_pkg::phase_t phase_reg, phase_next, phase_eff;
    logic [DW-1:0]    depth_reg, depth_next, depth_eff;
    logic [7:0]       pairs_reg, pairs_next, pairs_eff;
    logic [15:0]      bytes_reg, bytes_next, bytes_eff, bytes_dec;
    logic [7:0]       color_reg, color_next, color_eff;
    logic [7:0]       col_depth_reg;
    logic [DW:0]      skip_sum;
    logic [DW-1:0]    depth_inc;
    logic [7:0]       pairs_dec;
    logic             depth_done;
    logic             inc_done;
    logic             overrun;
    logic             step;

    assign step = item_valid && advance;

    always_comb begin
        phase_eff = phase_reg;
        depth_eff = depth_reg;
        pairs_eff = pairs_reg;
        bytes_eff = bytes_reg;
        color_eff = color_reg;
        if (item.column_start) begin
            depth_eff = '0;
            pairs_eff = '0;
            color_eff = '0;
            bytes_eff = item.column_length;
            phase_eff = (item.column_length == 16'd0 || col_depth_reg == 8'd0) ?
                        vcsd_pkg::PH_IDLE : vcsd_pkg::PH_SKIP;
        end
    end

    assign bytes_dec  = bytes_eff - 16'd1;
    assign skip_sum   = {1'b0, depth_eff} + {{(DW-7){1'b0}}, item.span_byte};
    assign depth_inc  = depth_eff + {{(DW-1){1'b0}}, 1'b1};
    assign pairs_dec  = pairs_eff - 8'd1;
    assign depth_done = depth_eff >= {{(DW-8){1'b0}}, col_depth_reg};
    assign inc_done   = depth_inc >= {{(DW-8){1'b0}}, col_depth_reg};
    assign overrun    = {8'd0, item.span_byte, 1'b0} > {1'b0, bytes_dec};

    always_comb begin
        phase_next   = phase_eff;
        depth_next   = depth_eff;
        pairs_next   = pairs_eff;
        bytes_next   = bytes_eff;
        color_next   = color_eff;
        result.valid = 1'b0;
        result.item  = '0;
        if (phase_eff == vcsd_pkg::PH_IDLE || bytes_eff == 16'd0) begin
            phase_next = vcsd_pkg::PH_IDLE;
        end else begin
            bytes_next = bytes_dec;
            unique case (phase_eff)
                vcsd_pkg::PH_SKIP: begin
                    depth_next = skip_sum[DW] ? vcsd_pkg::DepthMax : skip_sum[DW-1:0];
                    phase_next = vcsd_pkg::PH_COUNT;
                end
                vcsd_pkg::PH_COUNT: begin
                    if (overrun) begin
                        result.valid          = 1'b1;
                        result.item.run_error = 1'b1;
                        phase_next            = vcsd_pkg::PH_IDLE;
                    end else begin
                        pairs_next = item.span_byte;
                        if (depth_done) begin
                            phase_next = vcsd_pkg::PH_IDLE;
                        end else if (item.span_byte == 8'd0) begin
                            phase_next = vcsd_pkg::PH_REPEAT;
                        end else begin
                            phase_next = vcsd_pkg::PH_COLOR;
                        end
                    end
                end
                vcsd_pkg::PH_COLOR: begin
                    color_next = item.span_byte;
                    phase_next = vcsd_pkg::PH_NORMAL;
                end
                vcsd_pkg::PH_NORMAL: begin
                    result.valid             = 1'b1;
                    result.item.voxel_depth  = depth_eff[7:0];
                    result.item.voxel_color  = color_eff;
                    result.item.normal_index = item.span_byte;
                    depth_next               = depth_inc;
                    pairs_next               = pairs_dec;
                    if (inc_done) begin
                        phase_next = vcsd_pkg::PH_IDLE;
                    end else if (pairs_dec == 8'd0) begin
                        phase_next = vcsd_pkg::PH_REPEAT;
                    end else begin
                        phase_next = vcsd_pkg::PH_COLOR;
                    end
                end
                vcsd_pkg::PH_REPEAT: begin
                    phase_next = depth_done ? vcsd_pkg::PH_IDLE : vcsd_pkg::PH_SKIP;
                end
                default: begin
                    phase_next = vcsd_pkg::PH_IDLE;
                end
            endcase
            if (bytes_dec == 16'd0) begin
                phase_next = vcsd_pkg::PH_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= vcsd_pkg::PH_IDLE;
            depth_reg     <= '0;
            pairs_reg     <= '0;
            bytes_reg     <= '0;
            color_reg     <= '0;
            col_depth_reg <= vcsd_pkg::ColumnDepthReset;
        end else begin
            if (step) begin
                phase_reg <= phase_next;
                depth_reg <= depth_next;
                pairs_reg <= pairs_next;
                bytes_reg <= bytes_next;
                color_reg <= color_next;
            end
            if (cfg_valid) begin
                col_depth_reg <= cfg_data;
            end
        end
    end

endmodule
`default_nettype wire

[hw/rtl/vcsd_out_reg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Voxel column span decoder result register
// Holds one result until the downstream transfer and sets the stage advance.
// ----------------------------------------------------------------------------
module vcsd_out_reg (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              item_valid,
    input  wire vcsd_pkg::result_t result,
    output logic                   advance,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output vcsd_pkg::out_item_t    m_data
);

    logic                valid_reg;
    logic                valid_next;
    vcsd_pkg::out_item_t data_reg;

    assign advance    = !valid_reg || m_ready;
    assign valid_next = advance ? (item_valid && result.valid) : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && item_valid && result.valid) begin
            data_reg <= result.item;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule
`default_nettype wire

[tb/sv/voxel_column_span_decoder_unit_test.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Voxel column span decoder testbench
// Feeds span bytes through the input channel and checks each voxel or overrun
// result against a cycle-free model of the column decoder kept in this file.
// A directed sequence covers column boundaries, overruns and depth limits,
// then random columns run under several column depths and stall patterns.
// ----------------------------------------------------------------------------
module voxel_column_span_decoder_unit_test;

    localparam int HalfPeriod = 5;
    localparam int QuietCycles = 6;
    localparam int PhaseBytes = 220;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    vcsd_pkg::in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    vcsd_pkg::out_item_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [7:0] cfg_data = '0;

    vcsd_pkg::in_item_t span_feed[$];
    vcsd_pkg::out_item_t voxel_expect[$];
    int bytes_queued = 0;
    int bytes_taken = 0;
    int mismatch_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit byte_taken = 1'b0;

    vcsd_pkg::phase_t col_phase = vcsd_pkg::PH_IDLE;
    logic [8:0] depth_pos = '0;
    logic [7:0] pairs_todo = '0;
    logic [15:0] col_bytes = '0;
    logic [7:0] pending_color = '0;
    logic [7:0] depth_limit = vcsd_pkg::ColumnDepthReset;

    voxel_column_span_decoder_unit u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always #(HalfPeriod) aclk = ~aclk;

    task automatic decode_span_byte(input vcsd_pkg::in_item_t it);
        logic [9:0] sum;
        vcsd_pkg::out_item_t res;
        if (it.column_start) begin
            depth_pos = '0;
            pairs_todo = '0;
            pending_color = '0;
            col_bytes = it.column_length;
            col_phase = (col_bytes == 0 || depth_limit == 0) ?
                        vcsd_pkg::PH_IDLE : vcsd_pkg::PH_SKIP;
        end
        if (col_phase == vcsd_pkg::PH_IDLE || col_bytes == 0) begin
            col_phase = vcsd_pkg::PH_IDLE;
            return;
        end
        col_bytes = col_bytes - 16'd1;
        case (col_phase)
            vcsd_pkg::PH_SKIP: begin
                sum = {1'b0, depth_pos} + {2'b00, it.span_byte};
                depth_pos = (sum > {1'b0, vcsd_pkg::DepthMax}) ?
                            vcsd_pkg::DepthMax : sum[8:0];
                col_phase = vcsd_pkg::PH_COUNT;
            end
            vcsd_pkg::PH_COUNT: begin
                if ({it.span_byte, 1'b0} > col_bytes) begin
                    res = '0;
                    res.run_error = 1'b1;
                    voxel_expect.push_back(res);
                    col_phase = vcsd_pkg::PH_IDLE;
                end else begin
                    pairs_todo = it.span_byte;
                    if (depth_pos >= depth_limit) begin
                        col_phase = vcsd_pkg::PH_IDLE;
                    end else begin
                        col_phase = (it.span_byte == 0) ?
                                    vcsd_pkg::PH_REPEAT : vcsd_pkg::PH_COLOR;
                    end
                end
            end
            vcsd_pkg::PH_COLOR: begin
                pending_color = it.span_byte;
                col_phase = vcsd_pkg::PH_NORMAL;
            end
            vcsd_pkg::PH_NORMAL: begin
                res.voxel_depth = depth_pos[7:0];
                res.voxel_color = pending_color;
                res.normal_index = it.span_byte;
                res.run_error = 1'b0;
                voxel_expect.push_back(res);
                depth_pos = depth_pos + 9'd1;
                pairs_todo = pairs_todo - 8'd1;
                if (depth_pos >= depth_limit) begin
                    col_phase = vcsd_pkg::PH_IDLE;
                end else begin
                    col_phase = (pairs_todo == 0) ?
                                vcsd_pkg::PH_REPEAT : vcsd_pkg::PH_COLOR;
                end
            end
            vcsd_pkg::PH_REPEAT: begin
                col_phase = (depth_pos >= depth_limit) ?
                            vcsd_pkg::PH_IDLE : vcsd_pkg::PH_SKIP;
            end
            default: begin
                col_phase = vcsd_pkg::PH_IDLE;
            end
        endcase
        if (col_bytes == 0) col_phase = vcsd_pkg::PH_IDLE;
    endtask

    task automatic check_voxel(input vcsd_pkg::out_item_t got);
        vcsd_pkg::out_item_t want;
        if (voxel_expect.size() == 0) begin
            $error("unexpected result: depth %0d color %0d normal %0d error %0d",
                   got.voxel_depth, got.voxel_color, got.normal_index, got.run_error);
            mismatch_count++;
            return;
        end
        want = voxel_expect.pop_front();
        if (got.voxel_depth !== want.voxel_depth) begin
            $error("voxel_depth: expected %0d, got %0d", want.voxel_depth, got.voxel_depth);
            mismatch_count++;
        end
        if (got.voxel_color !== want.voxel_color) begin
            $error("voxel_color: expected %0d, got %0d", want.voxel_color, got.voxel_color);
            mismatch_count++;
        end
        if (got.normal_index !== want.normal_index) begin
            $error("normal_index: expected %0d, got %0d", want.normal_index,
                   got.normal_index);
            mismatch_count++;
        end
        if (got.run_error !== want.run_error) begin
            $error("run_error: expected %0d, got %0d", want.run_error, got.run_error);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        byte_taken = 1'b0;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) depth_limit = cfg_data;
            if (s_valid && s_ready) begin
                decode_span_byte(s_data);
                bytes_taken++;
                byte_taken = 1'b1;
            end
            if (m_valid && m_ready) check_voxel(m_data);
        end
    end

    always @(negedge aclk) begin
        if (aresetn && (!s_valid || byte_taken)) begin
            if (span_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data <= span_feed.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic queue_bytes(input logic [7:0] seq[$], input bit fresh,
                               input logic [15:0] len);
        vcsd_pkg::in_item_t it;
        for (int i = 0; i < seq.size(); i++) begin
            it.span_byte = seq[i];
            it.column_start = fresh && (i == 0);
            it.column_length = it.column_start ? len : 16'($urandom);
            span_feed.push_back(it);
            bytes_queued++;
        end
    endtask

    task automatic queue_column(input int runs, input int skip_max, input int count_max,
                                input bit truncate);
        logic [7:0] seq[$];
        int cnt;
        int len;
        seq = {};
        for (int r = 0; r < runs; r++) begin
            seq.push_back(8'($urandom_range(skip_max)));
            cnt = $urandom_range(count_max);
            seq.push_back(8'(cnt));
            for (int p = 0; p < cnt; p++) begin
                seq.push_back(8'($urandom));
                seq.push_back(8'($urandom));
            end
            if (r != runs - 1 || $urandom_range(1) == 1) seq.push_back(8'(cnt));
        end
        len = truncate ? $urandom_range(1, seq.size()) : seq.size();
        queue_bytes(seq, 1'b1, 16'(len));
    endtask

    task automatic queue_noise(input int count);
        vcsd_pkg::in_item_t it;
        for (int i = 0; i < count; i++) begin
            it.span_byte = 8'($urandom);
            it.column_start = ($urandom_range(9) == 0);
            it.column_length = 16'($urandom);
            span_feed.push_back(it);
            bytes_queued++;
        end
    endtask

    task automatic wait_quiet();
        do @(negedge aclk); while (bytes_taken != bytes_queued || voxel_expect.size() != 0);
        repeat (QuietCycles) @(negedge aclk);
    endtask

    task automatic write_depth(input logic [7:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int pick;
        int target;
        logic [7:0] limits[6];
        limits = '{8'd1, 8'd255, 8'($urandom_range(2, 254)), 8'd8, 8'd255,
                   8'($urandom_range(1, 255))};
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 32;
        recv_idle_pct = 86;
        write_depth(8'd255);
        queue_bytes('{8'hFF}, 1'b0, 16'hFFFF);
        queue_bytes('{8'h00}, 1'b1, 16'd0);
        queue_bytes('{8'h00, 8'h01, 8'hFF, 8'h00, 8'h01}, 1'b1, 16'd5);
        queue_bytes('{8'hFE, 8'h01, 8'hAA, 8'h55}, 1'b1, 16'd4);
        queue_bytes('{8'h00, 8'hFF}, 1'b1, 16'd2);
        queue_bytes('{8'h05}, 1'b1, 16'd1);
        queue_bytes('{8'hFF, 8'h01}, 1'b1, 16'hFFFF);
        queue_bytes('{8'hFF, 8'h01}, 1'b1, 16'd2);
        queue_bytes('{8'h01, 8'h02, 8'hC0, 8'h0C}, 1'b1, 16'd8);
        wait_quiet();
        write_depth(8'd3);
        queue_bytes('{8'hC1, 8'h1C, 8'h99}, 1'b0, 16'd0);
        wait_quiet();
        write_depth(8'd0);
        queue_bytes('{8'h00, 8'h01}, 1'b1, 16'd2);

        for (int ph = 0; ph < 6; ph++) begin
            wait_quiet();
            send_idle_pct = (ph < 2) ? 32 : (ph < 4) ? 86 : 0;
            recv_idle_pct = (ph < 2) ? 86 : (ph < 4) ? 32 : 0;
            write_depth(limits[ph]);
            target = bytes_queued + PhaseBytes;
            while (bytes_queued < target) begin
                pick = $urandom_range(99);
                if (pick < 8) begin
                    queue_noise($urandom_range(1, 6));
                end else begin
                    queue_column($urandom_range(1, 4),
                                 ($urandom_range(9) == 0) ? 255 : 6,
                                 ($urandom_range(9) == 0) ? 40 : 5,
                                 pick < 20);
                end
            end
        end

        wait_quiet();
        repeat (10) @(negedge aclk);
        if (mismatch_count == 0 && voxel_expect.size() == 0) begin
            $display("voxel_column_span_decoder_unit test passed");
        end else begin
            $display("voxel_column_span_decoder_unit test failed");
        end
        $finish;
    end

    initial begin
        #(3000000);
        $display("voxel_column_span_decoder_unit test failed");
        $finish;
    end

endmodule
`default_nettype wire

[sim.f]
hw/rtl/vcsd_pkg.sv
hw/rtl/vcsd_in_reg.sv
hw/rtl/vcsd_core.sv
hw/rtl/vcsd_out_reg.sv
hw/rtl/voxel_column_span_decoder_unit.sv
tb/sv/voxel_column_span_decoder_unit_test.sv
